>>> design/sync_frame_deframer_fletcher_unit_assert.svh
// Assertion macros for the sync frame deframer.
// Included by the top module, which checks its own logic; needs clk and rst_n in scope.
`ifndef SYNC_FRAME_DEFRAMER_FLETCHER_UNIT_ASSERT_SVH
`define SYNC_FRAME_DEFRAMER_FLETCHER_UNIT_ASSERT_SVH

// implication checked on every edge out of reset
`define SFDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define SFDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sfdf_pkg.sv
// Shared types and constants for the sync frame deframer.
// No dependencies; used by every module of the block by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package sfdf_pkg;

  // register reset values
  localparam logic [15:0] SYNC_WORD_RST = 16'h62B5;
  localparam logic [15:0] MAX_LEN_RST   = 16'd256;

  // configuration register indexes
  localparam logic CFG_SYNC_WORD = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_LEN_ERR = 2'd2;

  // parser phases, one-hot
  typedef enum logic [8:0] {
    PH_SYNC0 = 9'b000000001,
    PH_SYNC1 = 9'b000000010,
    PH_ID0   = 9'b000000100,
    PH_ID1   = 9'b000001000,
    PH_LEN0  = 9'b000010000,
    PH_LEN1  = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CK0   = 9'b010000000,
    PH_CK1   = 9'b100000000
  } phase_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic        checksum_ok;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
  } result_t;

endpackage

`default_nettype wire

>>> design/sfdf_parser.sv
// Frame parser: phase machine, header fields and running Fletcher sums.
// Depends on sfdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfdf_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire [7:0]            rx_byte,
  input  wire [15:0]           sync_word,
  input  wire [15:0]           max_len,
  output logic                 res_valid,
  output sfdf_pkg::result_t    res
);

  sfdf_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] frame_id_r, frame_id_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  check_low_r, check_low_nxt;

  // Fletcher add of the current byte onto the running sums
  logic [7:0] add_a;
  logic [7:0] add_b;
  assign add_a = sum_a_r + rx_byte;
  assign add_b = sum_b_r + add_a;

  // next state and result for the byte in the input register
  always_comb begin
    phase_nxt        = phase_r;
    frame_id_nxt     = frame_id_r;
    frame_length_nxt = frame_length_r;
    bytes_left_nxt   = bytes_left_r;
    sum_a_nxt        = sum_a_r;
    sum_b_nxt        = sum_b_r;
    check_low_nxt    = check_low_r;
    res_valid        = 1'b0;
    res              = '0;

    unique case (phase_r)
      sfdf_pkg::PH_SYNC1: begin
        phase_nxt = (rx_byte == sync_word[15:8]) ? sfdf_pkg::PH_ID0 : sfdf_pkg::PH_SYNC0;
      end
      sfdf_pkg::PH_ID0: begin
        // sums restart with the first id byte
        sum_a_nxt    = rx_byte;
        sum_b_nxt    = rx_byte;
        frame_id_nxt = {8'h00, rx_byte};
        phase_nxt    = sfdf_pkg::PH_ID1;
      end
      sfdf_pkg::PH_ID1: begin
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        frame_id_nxt = {rx_byte, frame_id_r[7:0]};
        phase_nxt    = sfdf_pkg::PH_LEN0;
      end
      sfdf_pkg::PH_LEN0: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        frame_length_nxt = {8'h00, rx_byte};
        phase_nxt        = sfdf_pkg::PH_LEN1;
      end
      sfdf_pkg::PH_LEN1: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        frame_length_nxt = {rx_byte, frame_length_r[7:0]};
        if (frame_length_nxt > max_len) begin
          // oversize frame: report and hunt again
          phase_nxt          = sfdf_pkg::PH_SYNC0;
          res_valid          = 1'b1;
          res.kind           = sfdf_pkg::KIND_LEN_ERR;
          res.message_id     = frame_id_r;
          res.payload_length = frame_length_nxt;
        end else begin
          bytes_left_nxt = frame_length_nxt;
          phase_nxt = (frame_length_nxt != 16'd0) ? sfdf_pkg::PH_DATA : sfdf_pkg::PH_CK0;
        end
      end
      sfdf_pkg::PH_DATA: begin
        sum_a_nxt      = add_a;
        sum_b_nxt      = add_b;
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          phase_nxt = sfdf_pkg::PH_CK0;
        end
        res_valid          = 1'b1;
        res.kind           = sfdf_pkg::KIND_DATA;
        res.data_byte      = rx_byte;
        res.byte_index     = frame_length_r - bytes_left_r;
        res.message_id     = frame_id_r;
        res.payload_length = frame_length_r;
      end
      sfdf_pkg::PH_CK0: begin
        check_low_nxt = rx_byte;
        phase_nxt     = sfdf_pkg::PH_CK1;
      end
      sfdf_pkg::PH_CK1: begin
        phase_nxt             = sfdf_pkg::PH_SYNC0;
        res_valid             = 1'b1;
        res.kind              = sfdf_pkg::KIND_END;
        res.message_id        = frame_id_r;
        res.payload_length    = frame_length_r;
        res.received_checksum = {rx_byte, check_low_r};
        res.computed_checksum = {sum_b_r, sum_a_r};
        res.checksum_ok       = ({rx_byte, check_low_r} == {sum_b_r, sum_a_r});
      end
      default: begin
        // hunting the first sync byte
        phase_nxt = (rx_byte == sync_word[7:0]) ? sfdf_pkg::PH_SYNC1 : sfdf_pkg::PH_SYNC0;
      end
    endcase
  end

  // state registers, advance once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sfdf_pkg::PH_SYNC0;
      frame_id_r     <= '0;
      frame_length_r <= '0;
      bytes_left_r   <= '0;
      sum_a_r        <= '0;
      sum_b_r        <= '0;
      check_low_r    <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      frame_id_r     <= frame_id_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      sum_a_r        <= sum_a_nxt;
      sum_b_r        <= sum_b_nxt;
      check_low_r    <= check_low_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sfdf_out_reg.sv
// Result register of the deframer: holds one result beat until taken.
// Depends on sfdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfdf_out_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  sfdf_pkg::result_t    res_in,
  input  wire                  out_stall,
  output logic                 free,
  output logic                 out_valid,
  output sfdf_pkg::result_t    res_out
);

  logic              valid_r;
  sfdf_pkg::result_t res_r;

  // slot can take a new beat when empty or being drained this edge
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

>>> design/sync_frame_deframer_fletcher_unit.sv
// A byte sits in the input register; its result beat then sits in the result register.
// Throughput: one byte per cycle; a byte stalls only while its result cannot enter a full,
// stalled result register. Bytes without a result pass even then.
// Reset (synchronous, rst_n low): registers back to sync 0x62B5 and maximum length 256,
// parser hunting the first sync byte, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "sync_frame_deframer_fletcher_unit_assert.svh"

module sync_frame_deframer_fletcher_unit (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_wdata,
  // received bytes
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_rx_byte,
  // results
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_message_id,
  output logic [15:0] out_payload_length,
  output logic        out_checksum_ok,
  output logic [15:0] out_received_checksum,
  output logic [15:0] out_computed_checksum
);

  logic [15:0] sync_word_r;
  logic [15:0] max_len_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_take;
  logic        res_valid;
  logic        out_free;
  sfdf_pkg::result_t res;
  sfdf_pkg::result_t res_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= sfdf_pkg::SYNC_WORD_RST;
      max_len_r   <= sfdf_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfdf_pkg::CFG_SYNC_WORD: sync_word_r <= cfg_wdata;
        sfdf_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: byte moves on unless its result is blocked
  assign s1_take  = s1_valid_r && (!res_valid || out_free);
  assign in_stall = s1_valid_r && !s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // parser between the two registers
  sfdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_take),
    .rx_byte   (s1_byte_r),
    .sync_word (sync_word_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  sfdf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_take && res_valid),
    .res_in    (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_kind              = res_out.kind;
  assign out_data_byte         = res_out.data_byte;
  assign out_byte_index        = res_out.byte_index;
  assign out_message_id        = res_out.message_id;
  assign out_payload_length    = res_out.payload_length;
  assign out_checksum_ok       = res_out.checksum_ok;
  assign out_received_checksum = res_out.received_checksum;
  assign out_computed_checksum = res_out.computed_checksum;

  // checks
  `SFDF_ASSERT_IMPL(a_no_stall_when_free, s1_valid_r && out_free, !in_stall,
    "input stalled although result slot is free")
  `SFDF_ASSERT_IMPL(a_ck_flag, out_valid && (out_kind == sfdf_pkg::KIND_END),
    out_checksum_ok == (out_received_checksum == out_computed_checksum),
    "checksum flag disagrees with checksums")
  `SFDF_ASSERT_IMPL(a_nondata_zero, out_valid && (out_kind != sfdf_pkg::KIND_DATA),
    (out_data_byte == 8'h00) && (out_byte_index == 16'h0000),
    "non-data result carries data fields")
  `SFDF_ASSERT_NEXT(a_result_source, !out_valid && !s1_valid_r, !out_valid,
    "result appeared without a byte in the input register")

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for sync_frame_deframer_fletcher_unit: random and directed byte
// streams, a cycle-free frame parser that predicts every result beat, field-by-field checks.
// Depends on sfdf_pkg (result kinds, register indexes, phase enum, result struct) and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 4;    // result register sits behind the input register
  localparam int QUIET_LIMIT   = 200;  // cycles with no beat on either side
  localparam int PRINT_LIMIT   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_index;
  logic [15:0] out_message_id;
  logic [15:0] out_payload_length;
  logic        out_checksum_ok;
  logic [15:0] out_received_checksum;
  logic [15:0] out_computed_checksum;

  sync_frame_deframer_fletcher_unit uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_data_byte         (out_data_byte),
    .out_byte_index        (out_byte_index),
    .out_message_id        (out_message_id),
    .out_payload_length    (out_payload_length),
    .out_checksum_ok       (out_checksum_ok),
    .out_received_checksum (out_received_checksum),
    .out_computed_checksum (out_computed_checksum)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // stimulus side: bytes waiting for the line, and the settings the generator frames for
  logic [7:0]  line_bytes[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned stim_count = 0;
  logic [15:0] gen_sync = sfdf_pkg::SYNC_WORD_RST;
  logic [15:0] gen_max = sfdf_pkg::MAX_LEN_RST;
  bit          calm = 1'b0;     // no idling on either side while set

  // parser tracking state, mirrors the block
  sfdf_pkg::phase_t trk_phase = sfdf_pkg::PH_SYNC0;
  logic [15:0] trk_id = '0;
  logic [15:0] trk_len = '0;
  logic [15:0] trk_left = '0;
  logic [7:0]  sum_a = '0;
  logic [7:0]  sum_b = '0;
  logic [7:0]  trk_ck_lo = '0;
  logic [15:0] trk_sync = sfdf_pkg::SYNC_WORD_RST;
  logic [15:0] trk_max = sfdf_pkg::MAX_LEN_RST;

  sfdf_pkg::result_t due_results[$];
  int unsigned beats_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic flag_error(input string msg);
    // print the first batch only, keep counting the rest
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch, beat %0d: %s", $time, beats_seen, msg);
    mismatch_count++;
  endtask

  task automatic fletcher_mix(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  // advance the tracked parser by one byte, queueing any result beat it causes
  task automatic deframe_byte(input logic [7:0] b);
    sfdf_pkg::result_t r;
    r = '0;
    r.message_id = trk_id;
    case (trk_phase)
      sfdf_pkg::PH_SYNC1:
        trk_phase = (b == trk_sync[15:8]) ? sfdf_pkg::PH_ID0 : sfdf_pkg::PH_SYNC0;
      sfdf_pkg::PH_ID0: begin
        sum_a = '0;
        sum_b = '0;
        fletcher_mix(b);
        trk_id = {8'h00, b};
        trk_phase = sfdf_pkg::PH_ID1;
      end
      sfdf_pkg::PH_ID1: begin
        fletcher_mix(b);
        trk_id[15:8] = b;
        trk_phase = sfdf_pkg::PH_LEN0;
      end
      sfdf_pkg::PH_LEN0: begin
        fletcher_mix(b);
        trk_len = {8'h00, b};
        trk_phase = sfdf_pkg::PH_LEN1;
      end
      sfdf_pkg::PH_LEN1: begin
        fletcher_mix(b);
        trk_len[15:8] = b;
        if (trk_len > trk_max) begin
          r.kind = sfdf_pkg::KIND_LEN_ERR;
          r.message_id = trk_id;
          r.payload_length = trk_len;
          due_results.push_back(r);
          trk_phase = sfdf_pkg::PH_SYNC0;
        end else begin
          trk_left = trk_len;
          trk_phase = (trk_len != 16'd0) ? sfdf_pkg::PH_DATA : sfdf_pkg::PH_CK0;
        end
      end
      sfdf_pkg::PH_DATA: begin
        fletcher_mix(b);
        r.kind = sfdf_pkg::KIND_DATA;
        r.data_byte = b;
        r.byte_index = trk_len - trk_left;
        r.payload_length = trk_len;
        trk_left = trk_left - 16'd1;
        if (trk_left == 16'd0) trk_phase = sfdf_pkg::PH_CK0;
        due_results.push_back(r);
      end
      sfdf_pkg::PH_CK0: begin
        trk_ck_lo = b;
        trk_phase = sfdf_pkg::PH_CK1;
      end
      sfdf_pkg::PH_CK1: begin
        r.kind = sfdf_pkg::KIND_END;
        r.payload_length = trk_len;
        r.received_checksum = {b, trk_ck_lo};
        r.computed_checksum = {sum_b, sum_a};
        r.checksum_ok = (r.received_checksum == r.computed_checksum);
        due_results.push_back(r);
        trk_phase = sfdf_pkg::PH_SYNC0;
      end
      default:
        trk_phase = (b == trk_sync[7:0]) ? sfdf_pkg::PH_SYNC1 : sfdf_pkg::PH_SYNC0;
    endcase
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (line_bytes.size() != 0) begin
        in_rx_byte <= line_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall after each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) recv_gap = draw_gap();
    end
  end

  // monitor: register writes, result checks, then prediction for the accepted byte
  always @(posedge clk) begin
    sfdf_pkg::result_t want;
    if (!rst_n) begin
      trk_phase = sfdf_pkg::PH_SYNC0;
      trk_sync = sfdf_pkg::SYNC_WORD_RST;
      trk_max = sfdf_pkg::MAX_LEN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfdf_pkg::CFG_SYNC_WORD: trk_sync = cfg_wdata;
          sfdf_pkg::CFG_MAX_LEN:   trk_max = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_error($sformatf("unexpected beat, kind %0d", out_kind));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            flag_error($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_data_byte !== want.data_byte)
            flag_error($sformatf("data_byte %h, want %h", out_data_byte, want.data_byte));
          if (out_byte_index !== want.byte_index)
            flag_error($sformatf("byte_index %0d, want %0d", out_byte_index,
                                 want.byte_index));
          if (out_message_id !== want.message_id)
            flag_error($sformatf("message_id %h, want %h", out_message_id,
                                 want.message_id));
          if (out_payload_length !== want.payload_length)
            flag_error($sformatf("payload_length %0d, want %0d", out_payload_length,
                                 want.payload_length));
          if (out_checksum_ok !== want.checksum_ok)
            flag_error($sformatf("checksum_ok %b, want %b", out_checksum_ok,
                                 want.checksum_ok));
          if (out_received_checksum !== want.received_checksum)
            flag_error($sformatf("received_checksum %h, want %h", out_received_checksum,
                                 want.received_checksum));
          if (out_computed_checksum !== want.computed_checksum)
            flag_error($sformatf("computed_checksum %h, want %h", out_computed_checksum,
                                 want.computed_checksum));
        end
        beats_seen++;
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        bytes_taken++;
      end
    end
  end

  // watchdog: cycles with no beat accepted on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic queue_byte(input logic [7:0] b);
    line_bytes.push_back(b);
    bytes_queued++;
  endtask

  // one frame for the current sync word; cut > 0 truncates it to that many bytes
  task automatic queue_frame(input logic [15:0] id, input logic [15:0] len,
                             input bit bad_sum, input int unsigned cut);
    logic [7:0]  frame[$];
    logic [7:0]  hdr[4];
    logic [7:0]  a, b, pick;
    int unsigned n;
    frame = {};
    a = '0;
    b = '0;
    hdr = '{id[7:0], id[15:8], len[7:0], len[15:8]};
    frame.push_back(gen_sync[7:0]);
    frame.push_back(gen_sync[15:8]);
    for (int i = 0; i < 4; i++) begin
      frame.push_back(hdr[i]);
      a = a + hdr[i];
      b = b + a;
    end
    // an oversize length ends the frame at the header
    if (len <= gen_max) begin
      for (int i = 0; i < len; i++) begin
        pick = 8'($urandom);
        frame.push_back(pick);
        a = a + pick;
        b = b + a;
      end
      if (bad_sum) begin
        if ($urandom_range(0, 1) != 0) a = a ^ 8'($urandom_range(1, 255));
        else b = b ^ 8'($urandom_range(1, 255));
      end
      frame.push_back(a);
      frame.push_back(b);
    end
    n = (cut != 0 && cut < frame.size()) ? cut : frame.size();
    for (int i = 0; i < n; i++) queue_byte(frame[i]);
    stim_count += n;
  endtask

  function automatic logic [15:0] pick_len();
    if (gen_max <= 16'd24) return 16'($urandom_range(0, gen_max));
    if (gen_max <= 16'd300 && $urandom_range(0, 11) == 0) return gen_max;
    return 16'($urandom_range(0, 24));
  endfunction

  // mostly good frames with random content, plus bad sums, oversize, cut frames and noise
  task automatic queue_traffic(input int unsigned n);
    int unsigned stop_at, roll, len, cnt;
    logic [7:0]  b;
    stop_at = stim_count + n;
    while (stim_count < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        queue_frame(16'($urandom), pick_len(), ($urandom_range(0, 4) == 0), 0);
      end else if (roll < 80 && gen_max != 16'hFFFF) begin
        len = gen_max + $urandom_range(1, 40);
        if (len > 32'hFFFF || $urandom_range(0, 7) == 0) len = 32'hFFFF;
        queue_frame(16'($urandom), len[15:0], 1'b0, 0);
      end else if (roll < 88) begin
        queue_frame(16'($urandom), pick_len(), 1'b0, $urandom_range(1, 8));
      end else if (roll < 94) begin
        // first sync byte followed by a wrong second one
        b = 8'($urandom);
        if (b == gen_sync[15:8]) b = ~b;
        queue_byte(gen_sync[7:0]);
        queue_byte(b);
      end else begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) queue_byte(8'($urandom));
      end
    end
  endtask

  // wait until every byte is taken and every result has come, then let the pipe empty
  task automatic settle();
    while (bytes_taken != bytes_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfdf_pkg::CFG_SYNC_WORD) gen_sync = val;
    else gen_max = val;
  endtask

  task automatic run_all();
    // directed: zero length, wrong second sync, full-range id, oversize length
    queue_frame(16'h0000, 16'h0000, 1'b0, 0);
    queue_byte(gen_sync[7:0]);
    queue_byte(gen_sync[7:0]);   // repeat of the first sync byte is not a new start
    queue_byte(gen_sync[15:8]);
    queue_frame(16'hFFFF, 16'd2, 1'b0, 0);
    queue_frame(16'h1234, 16'hFFFF, 1'b0, 0);
    queue_traffic(150);
    settle();

    // stop inside a header, then lower the maximum before the length high byte
    queue_frame(16'hA55A, 16'd5, 1'b0, 5);
    settle();
    write_reg(sfdf_pkg::CFG_MAX_LEN, 16'd0);
    write_reg(sfdf_pkg::CFG_SYNC_WORD, 16'h0000);
    queue_byte(8'h00);
    queue_traffic(80);
    settle();

    write_reg(sfdf_pkg::CFG_SYNC_WORD, 16'hFFFF);
    write_reg(sfdf_pkg::CFG_MAX_LEN, 16'd1);
    queue_traffic(80);
    settle();

    // widest maximum, payload index past one byte, run without idling
    calm = 1'b1;
    write_reg(sfdf_pkg::CFG_MAX_LEN, 16'hFFFF);
    queue_frame(16'($urandom), 16'd257, 1'b0, 0);
    queue_traffic(40);
    settle();

    calm = 1'b0;
    write_reg(sfdf_pkg::CFG_SYNC_WORD, 16'($urandom));
    write_reg(sfdf_pkg::CFG_MAX_LEN, 16'($urandom_range(2, 40)));
    queue_traffic(150);
    settle();

    calm = 1'b1;
    write_reg(sfdf_pkg::CFG_SYNC_WORD, 16'h5A5A);
    write_reg(sfdf_pkg::CFG_MAX_LEN, 16'd16);
    queue_traffic(60);
    settle();
  endtask

  initial begin
    bit stuck;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    fork
      run_all();
      wait (quiet_cycles >= QUIET_LIMIT);
    join_any
    stuck = (quiet_cycles >= QUIET_LIMIT);
    if (stuck) $display("[%0t] watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d result beats never arrived", due_results.size()));
    if (!stuck && mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
